FILE: hw/rtl/r2fft_pkg.sv
package r2fft_pkg;

  localparam int DATA_W  = 30;
  localparam int SAMPLE_W = 16;
  localparam int TW_W    = 16;
  localparam int ADDR_W  = 6;
  localparam int LOG_W   = 3;
  localparam int OUT_PER_ITEM = 8;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RD_BOT,
    ST_RD_TOP,
    ST_MUL,
    ST_SUM,
    ST_WR_BOT,
    ST_WR_TOP,
    ST_DRAIN_RD,
    ST_DRAIN_OUT,
    ST_WAIT
  } fft_state_t;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_RD_BOT,
    CMD_RD_TOP,
    CMD_MUL,
    CMD_SUM,
    CMD_WR_BOT,
    CMD_WR_TOP
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [ADDR_W-1:0] addr;
    logic [4:0]        tw_idx;
  } dp_cmd_t;

  function automatic logic [TW_W-1:0] quarter_cos(input logic [4:0] j);
    logic [TW_W-1:0] v;
    case (j)
      5'd0:  v = 16'd32767;
      5'd1:  v = 16'd32610;
      5'd2:  v = 16'd32138;
      5'd3:  v = 16'd31357;
      5'd4:  v = 16'd30274;
      5'd5:  v = 16'd28899;
      5'd6:  v = 16'd27246;
      5'd7:  v = 16'd25330;
      5'd8:  v = 16'd23170;
      5'd9:  v = 16'd20788;
      5'd10: v = 16'd18205;
      5'd11: v = 16'd15447;
      5'd12: v = 16'd12540;
      5'd13: v = 16'd9512;
      5'd14: v = 16'd6393;
      5'd15: v = 16'd3212;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat30(input logic signed [DATA_W+1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 32'sd536870911) begin
      r = 30'sd536870911;
    end else if (v < -32'sd536870912) begin
      r = -30'sd536870912;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/r2fft_if.sv
interface r2fft_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface r2fft_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [r2fft_pkg::DATA_W-1:0]   bin_real;
  logic signed [r2fft_pkg::DATA_W-1:0]   bin_imag;
  logic [r2fft_pkg::ADDR_W-1:0]          bin_index;
  logic                                  last_bin;
  modport source (output valid, output bin_real, output bin_imag, output bin_index,
                  output last_bin, input ready);
  modport sink (input valid, input bin_real, input bin_imag, input bin_index,
                input last_bin, output ready);
endinterface

FILE: hw/rtl/radix2_fft.sv
// channel  | dir | payload                                  | handshake
// in_ch    | in  | sample                                   | valid/ready
// out_ch   | out | bin_real, bin_imag, bin_index, last_bin  | valid/ready
// cfg      | in  | log2_points at address 0                 | APB, pready high
// Loading: one sample a cycle. After the n-th sample, n/2*log2(n) butterflies
// (read bottom, read top, multiply, sum, write bottom, write top) run through
// the single-port working store; 8 bins leave per drain item, its sample dropped.
// Reset (rst, synchronous) returns to loading with log2_points 3.
// Output stalls hold the bin in place; the store is not refreshed meanwhile.
module radix2_fft #(
  parameter int POINTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  r2fft_in_if.sink    in_ch,
  r2fft_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int MAX_LOG = (POINTS >= 64) ? 6 : $clog2(POINTS + 1) - 1;

  r2fft_pkg::dp_cmd_t cmd;
  logic [r2fft_pkg::LOG_W-1:0] log2_points;
  logic cfg_we, out_load;
  logic signed [r2fft_pkg::DATA_W-1:0] rd_real, rd_imag;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == 1'b0);
  assign prdata = {29'd0, log2_points};

  r2fft_ctrl #(.MAX_LOG(MAX_LOG)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_log     (pwdata[2:0]),
    .log2_points (log2_points),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_index   (out_ch.bin_index),
    .out_last    (out_ch.last_bin),
    .out_load    (out_load),
    .cmd         (cmd)
  );

  r2fft_datapath u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .sample  (in_ch.sample),
    .rd_real (rd_real),
    .rd_imag (rd_imag)
  );

  assign out_ch.bin_real = out_load ? '0 : rd_real;
  assign out_ch.bin_imag = out_load ? '0 : rd_imag;

endmodule

FILE: hw/rtl/r2fft_datapath.sv
module r2fft_datapath (
  input  logic                                  clk,
  input  r2fft_pkg::dp_cmd_t                    cmd,
  input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample,
  output logic signed [r2fft_pkg::DATA_W-1:0]   rd_real,
  output logic signed [r2fft_pkg::DATA_W-1:0]   rd_imag
);

  localparam int DW = r2fft_pkg::DATA_W;
  localparam int PW = DW + 17;

  logic signed [DW-1:0] mem_real [64];
  logic signed [DW-1:0] mem_imag [64];
  logic signed [DW-1:0] bot_real, bot_imag, top_real, top_imag;
  logic signed [PW-1:0] p_ac, p_bs, p_bc, p_as;
  logic signed [DW+1:0] pr, pi;
  logic signed [DW-1:0] res_top_real, res_top_imag, res_bot_real, res_bot_imag;
  logic signed [16:0]   tw_c, tw_s;
  logic [4:0]           j;
  logic signed [PW:0]   sum_r, sum_i;
  logic signed [DW-1:0] wr_real, wr_imag;
  logic                 wr_en;

  assign j = cmd.tw_idx;

  always_comb begin
    if (j <= 5'd16) begin
      tw_c = $signed({1'b0, r2fft_pkg::quarter_cos(j)});
      tw_s = $signed({1'b0, r2fft_pkg::quarter_cos(5'd16 - j)});
    end else begin
      tw_c = -$signed({1'b0, r2fft_pkg::quarter_cos(5'd0 - j)});
      tw_s = $signed({1'b0, r2fft_pkg::quarter_cos(j - 5'd16)});
    end
  end

  assign sum_r = (PW+1)'(p_ac) + (PW+1)'(p_bs) + (PW+1)'(16384);
  assign sum_i = (PW+1)'(p_bc) - (PW+1)'(p_as) + (PW+1)'(16384);

  always_comb begin
    wr_en   = 1'b0;
    wr_real = res_bot_real;
    wr_imag = res_bot_imag;
    case (cmd.op)
      r2fft_pkg::CMD_LOAD: begin
        wr_en   = 1'b1;
        wr_real = {{(DW-24){sample[15]}}, sample, 8'd0};
        wr_imag = '0;
      end
      r2fft_pkg::CMD_WR_BOT: wr_en = 1'b1;
      r2fft_pkg::CMD_WR_TOP: begin
        wr_en   = 1'b1;
        wr_real = res_top_real;
        wr_imag = res_top_imag;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_real[cmd.addr] <= wr_real;
      mem_imag[cmd.addr] <= wr_imag;
    end
    rd_real <= mem_real[cmd.addr];
    rd_imag <= mem_imag[cmd.addr];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      r2fft_pkg::CMD_RD_TOP: begin
        bot_real <= rd_real;
        bot_imag <= rd_imag;
      end
      r2fft_pkg::CMD_MUL: begin
        top_real <= rd_real;
        top_imag <= rd_imag;
        p_ac <= PW'(bot_real * tw_c);
        p_bs <= PW'(bot_imag * tw_s);
        p_bc <= PW'(bot_imag * tw_c);
        p_as <= PW'(bot_real * tw_s);
      end
      r2fft_pkg::CMD_SUM: begin
        pr <= (DW+2)'(sum_r >>> 15);
        pi <= (DW+2)'(sum_i >>> 15);
      end
      r2fft_pkg::CMD_WR_BOT: begin
        res_top_real <= r2fft_pkg::sat30((DW+2)'(top_real) + pr);
        res_top_imag <= r2fft_pkg::sat30((DW+2)'(top_imag) + pi);
      end
      default: begin
      end
    endcase
  end

  assign res_bot_real = r2fft_pkg::sat30((DW+2)'(top_real) - pr);
  assign res_bot_imag = r2fft_pkg::sat30((DW+2)'(top_imag) - pi);

endmodule

FILE: hw/rtl/r2fft_ctrl.sv
module r2fft_ctrl #(
  parameter int MAX_LOG = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [r2fft_pkg::LOG_W-1:0]      cfg_log,
  output logic [r2fft_pkg::LOG_W-1:0]      log2_points,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [r2fft_pkg::ADDR_W-1:0]     out_index,
  output logic                             out_last,
  output logic                             out_load,
  output r2fft_pkg::dp_cmd_t               cmd
);

  localparam int AW = r2fft_pkg::ADDR_W;

  r2fft_pkg::fft_state_t state, state_next;
  logic [AW:0]   load_count, load_count_next;
  logic [2:0]    stage, stage_next;
  logic [AW-1:0] bfly, bfly_next;
  logic [AW-1:0] drain_k, drain_k_next;
  logic [3:0]    burst, burst_next;
  logic [AW:0]   npts;
  logic [AW-1:0] rev, half_mask, top_addr, bot_addr, kk;
  logic [AW-1:0] base;
  logic [AW-1:0] stage_half;
  logic          last_bfly;

  assign npts = (AW+1)'(1) << log2_points;
  assign stage_half = AW'(1) << (stage - 3'd1);
  assign half_mask = stage_half - AW'(1);
  assign kk = bfly & half_mask;
  assign base = (bfly & ~half_mask) << 1;
  assign top_addr = base | kk;
  assign bot_addr = top_addr | stage_half;
  assign last_bfly = (bfly == AW'((npts >> 1) - 1));

  always_comb begin
    rev = '0;
    for (int b = 0; b < AW; b++) begin
      if (b < int'(log2_points)) begin
        rev[int'(log2_points) - 1 - b] = load_count[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= r2fft_pkg::ST_LOAD;
      load_count  <= '0;
      stage       <= 3'd1;
      bfly        <= '0;
      drain_k     <= '0;
      burst       <= '0;
      log2_points <= (3 > MAX_LOG) ? r2fft_pkg::LOG_W'(MAX_LOG) : r2fft_pkg::LOG_W'(3);
    end else if (cfg_we) begin
      state      <= r2fft_pkg::ST_LOAD;
      load_count <= '0;
      stage      <= 3'd1;
      bfly       <= '0;
      drain_k    <= '0;
      burst      <= '0;
      if (cfg_log < 3'd1) begin
        log2_points <= 3'd1;
      end else if (cfg_log > r2fft_pkg::LOG_W'(MAX_LOG)) begin
        log2_points <= r2fft_pkg::LOG_W'(MAX_LOG);
      end else begin
        log2_points <= cfg_log;
      end
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
      stage      <= stage_next;
      bfly       <= bfly_next;
      drain_k    <= drain_k_next;
      burst      <= burst_next;
    end
  end

  always_comb begin
    state_next      = state;
    load_count_next = load_count;
    stage_next      = stage;
    bfly_next       = bfly;
    drain_k_next    = drain_k;
    burst_next      = burst;
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    out_load        = 1'b0;
    cmd.op          = r2fft_pkg::CMD_IDLE;
    cmd.addr        = drain_k;
    cmd.tw_idx      = 5'(kk << (3'd6 - stage));
    case (state)
      r2fft_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        cmd.addr = rev;
        if (in_valid) begin
          cmd.op = r2fft_pkg::CMD_LOAD;
          load_count_next = load_count + 1'b1;
          if (load_count + 1'b1 == npts) begin
            state_next = r2fft_pkg::ST_RD_BOT;
            stage_next = 3'd1;
            bfly_next  = '0;
          end
        end
      end
      r2fft_pkg::ST_RD_BOT: begin
        cmd.op = r2fft_pkg::CMD_IDLE;
        cmd.addr = bot_addr;
        state_next = r2fft_pkg::ST_RD_TOP;
      end
      r2fft_pkg::ST_RD_TOP: begin
        cmd.op = r2fft_pkg::CMD_RD_TOP;
        cmd.addr = top_addr;
        state_next = r2fft_pkg::ST_MUL;
      end
      r2fft_pkg::ST_MUL: begin
        cmd.op = r2fft_pkg::CMD_MUL;
        state_next = r2fft_pkg::ST_SUM;
      end
      r2fft_pkg::ST_SUM: begin
        cmd.op = r2fft_pkg::CMD_SUM;
        state_next = r2fft_pkg::ST_WR_BOT;
      end
      r2fft_pkg::ST_WR_BOT: begin
        cmd.op = r2fft_pkg::CMD_WR_BOT;
        cmd.addr = bot_addr;
        state_next = r2fft_pkg::ST_WR_TOP;
      end
      r2fft_pkg::ST_WR_TOP: begin
        cmd.op = r2fft_pkg::CMD_WR_TOP;
        cmd.addr = top_addr;
        if (!last_bfly) begin
          bfly_next  = bfly + 1'b1;
          state_next = r2fft_pkg::ST_RD_BOT;
        end else if (stage != log2_points) begin
          bfly_next  = '0;
          stage_next = stage + 3'd1;
          state_next = r2fft_pkg::ST_RD_BOT;
        end else begin
          drain_k_next = '0;
          burst_next   = '0;
          state_next   = r2fft_pkg::ST_DRAIN_RD;
        end
      end
      r2fft_pkg::ST_DRAIN_RD: begin
        cmd.addr = drain_k;
        state_next = r2fft_pkg::ST_DRAIN_OUT;
      end
      r2fft_pkg::ST_DRAIN_OUT: begin
        out_valid = 1'b1;
        out_load  = 1'b0;
        if (out_ready) begin
          drain_k_next = drain_k + 1'b1;
          burst_next   = burst + 4'd1;
          if ((AW+1)'(drain_k) + 1'b1 == npts) begin
            load_count_next = '0;
            state_next = r2fft_pkg::ST_LOAD;
          end else if (burst + 4'd1 == 4'(r2fft_pkg::OUT_PER_ITEM)) begin
            state_next = r2fft_pkg::ST_WAIT;
          end else begin
            state_next = r2fft_pkg::ST_DRAIN_RD;
          end
        end
      end
      r2fft_pkg::ST_WAIT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          burst_next = '0;
          state_next = r2fft_pkg::ST_DRAIN_RD;
        end
      end
      default: state_next = r2fft_pkg::ST_LOAD;
    endcase
  end

  assign out_index = drain_k;
  assign out_last  = ((AW+1)'(drain_k) + 1'b1 == npts);

endmodule
